FILE: rtl/core/hbf_pkg.sv
// Shared types and constants of the HTTP body framer.
// Depends on nothing; every other file of the core imports it.
package hbf_pkg;

    // Item kinds on the input stream.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVER     = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // Status codes that carry no body besides the 1xx range.
    localparam logic [9:0] CODE_INFO_LO     = 10'd100;
    localparam logic [9:0] CODE_INFO_HI     = 10'd199;
    localparam logic [9:0] CODE_NO_CONTENT  = 10'd204;
    localparam logic [9:0] CODE_NOT_MODIFED = 10'd304;

    // Framing characters.
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_ALPHA_OFS = 8'h57;

    // Depth of the job queue between front and back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_CLEN  = 2'd1,
        MODE_CHUNK = 2'd2,
        MODE_CLOSE = 2'd3
    } mode_t;

    // What the back end has to emit for one accepted item.
    typedef enum logic [1:0] {
        J_EMPTY = 2'd0,
        J_BYTE  = 2'd1,
        J_CHUNK = 2'd2,
        J_ZERO  = 2'd3
    } jtype_t;

    typedef enum logic [2:0] {
        PH_NOBYTE,
        PH_DATA,
        PH_HEX,
        PH_HCR,
        PH_HLF,
        PH_TCR,
        PH_TLF
    } phase_t;

    // Decoded input item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  status_code;
        logic        is_head;
        logic [3:0]  minor_version;
        logic        keep_alive;
        logic        has_length;
        logic [31:0] decl_length;
        logic [7:0]  data_byte;
        logic        chunk_first;
        logic        chunk_last;
        logic [31:0] chunk_length;
    } item_t;

    // Job handed from front to back.
    typedef struct packed {
        jtype_t      jtype;
        logic [7:0]  data;
        logic        cfirst;
        logic        clast;
        logic [31:0] clen;
        logic [2:0]  ndig;     // number of hex digits minus one
        logic [1:0]  status;
        mode_t       mode;
        logic        close;
    } job_t;

    // One output beat.
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  out_byte;
        logic        last;
        logic [1:0]  status;
        mode_t       mode;
        logic        close;
    } res_t;

endpackage

FILE: rtl/core/hbf_front.sv
// Front end of the HTTP body framer: accepts items, keeps the response state
// and turns each item into one job for the back end. Depends on hbf_pkg.
module hbf_front #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hbf_pkg::item_t item,
    input  logic          q_full,
    output logic          push,
    output hbf_pkg::job_t push_job
);
    import hbf_pkg::*;

    localparam bit WRAP = (LENGTH_BITS == 64);

    mode_t                  mode_reg, mode_next;
    logic                   close_reg, close_next;
    logic                   complete_reg, complete_next;
    logic [LENGTH_BITS-1:0] exp_reg, exp_next;
    logic [LENGTH_BITS-1:0] sent_reg, sent_next;

    logic [LENGTH_BITS-1:0] len_sat;
    logic [LENGTH_BITS:0]   sent_inc;
    logic                   over;
    logic                   v11;
    logic                   forbidden;
    logic [2:0]             ndig_m1;
    job_t                   job;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign push_job = job;

    // Declared length, saturated to the counter width.
    generate
        if (LENGTH_BITS >= 32) begin : g_len_wide
            assign len_sat = LENGTH_BITS'(item.decl_length);
        end
        else begin : g_len_narrow
            assign len_sat = (|item.decl_length[31:LENGTH_BITS]) ? '1
                           : item.decl_length[LENGTH_BITS-1:0];
        end
    endgenerate

    // A byte fits while the incremented count stays within the limit.
    assign sent_inc = {1'b0, sent_reg} + (LENGTH_BITS+1)'(1);
    assign over     = WRAP ? (sent_inc[LENGTH_BITS-1:0] > exp_reg)
                           : (sent_inc > {1'b0, exp_reg});

    assign v11 = (item.minor_version != 4'd0);

    // Status codes that forbid a body.
    always_comb
    begin
        forbidden = item.status_code inside {[CODE_INFO_LO:CODE_INFO_HI],
                                             CODE_NO_CONTENT, CODE_NOT_MODIFED};
    end

    // Number of hex digits of the chunk length, at least one.
    always_comb
    begin
        ndig_m1 = 3'd0;
        for (int i = 1; i < 8; i++)
        begin
            if (item.chunk_length[4*i +: 4] != 4'd0)
                ndig_m1 = 3'(i);
        end
    end

    // Classify the item and compute the next response state.
    always_comb
    begin
        mode_next     = mode_reg;
        close_next    = close_reg;
        complete_next = complete_reg;
        exp_next      = exp_reg;
        sent_next     = sent_reg;

        job        = '0;
        job.jtype  = J_EMPTY;
        job.status = ST_OK;
        job.data   = item.data_byte;
        job.cfirst = item.chunk_first;
        job.clast  = item.chunk_last;
        job.clen   = item.chunk_length;
        job.ndig   = ndig_m1;

        case (item.kind)
            KIND_START:
            begin
                sent_next     = '0;
                exp_next      = '0;
                complete_next = 1'b0;
                if (item.is_head || forbidden)
                begin
                    mode_next     = MODE_NONE;
                    complete_next = 1'b1;
                end
                else if (item.has_length)
                begin
                    mode_next = MODE_CLEN;
                    exp_next  = len_sat;
                end
                else if (v11)
                    mode_next = MODE_CHUNK;
                else
                    mode_next = MODE_CLOSE;
                close_next = v11 ? !item.keep_alive
                                 : (!item.keep_alive || mode_next == MODE_CLOSE);
            end
            KIND_BYTE:
            begin
                if (!complete_reg)
                begin
                    case (mode_reg)
                        MODE_CLEN:
                        begin
                            if (over)
                                job.status = ST_OVER;
                            else
                            begin
                                sent_next = sent_inc[LENGTH_BITS-1:0];
                                job.jtype = J_BYTE;
                            end
                        end
                        MODE_CHUNK: job.jtype = J_CHUNK;
                        MODE_CLOSE: job.jtype = J_BYTE;
                        default:    job.jtype = J_EMPTY;
                    endcase
                end
            end
            KIND_END:
            begin
                if (!complete_reg)
                begin
                    if (mode_reg == MODE_CLEN && sent_reg != exp_reg)
                        job.status = ST_MISMATCH;
                    else
                    begin
                        if (mode_reg == MODE_CHUNK)
                        begin
                            job.jtype = J_ZERO;
                            job.clen  = '0;
                            job.ndig  = 3'd0;
                        end
                        complete_next = 1'b1;
                    end
                end
            end
            default:
            begin
                job.jtype = J_EMPTY;
            end
        endcase

        job.mode  = mode_next;
        job.close = close_next;
    end

    // Response state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NONE;
            close_reg    <= 1'b0;
            complete_reg <= 1'b0;
            exp_reg      <= '0;
            sent_reg     <= '0;
        end
        else if (push)
        begin
            mode_reg     <= mode_next;
            close_reg    <= close_next;
            complete_reg <= complete_next;
            exp_reg      <= exp_next;
            sent_reg     <= sent_next;
        end
    end

endmodule

FILE: rtl/core/hbf_queue.sv
// Short job queue between the front and back ends of the body framer.
// Depends on hbf_pkg for the job type and depth.
module hbf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hbf_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output hbf_pkg::job_t head
);
    import hbf_pkg::*;

    job_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    // Occupancy follows push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (Q_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (Q_AW+1)'(1);
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            count_reg <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: rtl/core/hbf_back.sv
// Back end of the body framer: expands each queued job into output beats
// (chunk header, data, CRLF, zero chunk) behind an output register.
// Depends on hbf_pkg.
module hbf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  hbf_pkg::job_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output hbf_pkg::res_t out_res
);
    import hbf_pkg::*;

    logic       busy_reg, busy_next;
    phase_t     ph_reg, ph_next;
    logic [2:0] dig_reg, dig_next;
    logic       valid_reg;
    res_t       res_reg;

    phase_t     start_ph;
    phase_t     cur_ph;
    logic [2:0] cur_dig;
    logic [3:0] nib;
    logic       load;
    res_t       beat;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // First phase of a fresh job.
    always_comb
    begin
        case (head.jtype)
            J_BYTE:  start_ph = PH_DATA;
            J_CHUNK: start_ph = head.cfirst ? PH_HEX : PH_DATA;
            J_ZERO:  start_ph = PH_HEX;
            default: start_ph = PH_NOBYTE;
        endcase
    end

    assign cur_ph  = busy_reg ? ph_reg : start_ph;
    assign cur_dig = busy_reg ? dig_reg : head.ndig;
    assign nib     = head.clen[{cur_dig, 2'b00} +: 4];

    // Current beat and the phase that follows it.
    always_comb
    begin
        beat          = '0;
        beat.status   = head.status;
        beat.mode     = head.mode;
        beat.close    = head.close;
        beat.has_byte = 1'b1;
        ph_next       = cur_ph;
        dig_next      = cur_dig;
        case (cur_ph)
            PH_NOBYTE:
            begin
                beat.has_byte = 1'b0;
                beat.last     = 1'b1;
            end
            PH_DATA:
            begin
                beat.out_byte = head.data;
                if (head.jtype == J_CHUNK && head.clast)
                    ph_next = PH_TCR;
                else
                    beat.last = 1'b1;
            end
            PH_HEX:
            begin
                beat.out_byte = (nib < 4'd10) ? (CH_DIGIT_0 + 8'(nib))
                                              : (CH_ALPHA_OFS + 8'(nib));
                if (cur_dig == 3'd0)
                    ph_next = PH_HCR;
                else
                    dig_next = cur_dig - 3'd1;
            end
            PH_HCR:
            begin
                beat.out_byte = CH_CR;
                ph_next       = PH_HLF;
            end
            PH_HLF:
            begin
                beat.out_byte = CH_LF;
                ph_next       = (head.jtype == J_ZERO) ? PH_TCR : PH_DATA;
            end
            PH_TCR:
            begin
                beat.out_byte = CH_CR;
                ph_next       = PH_TLF;
            end
            PH_TLF:
            begin
                beat.out_byte = CH_LF;
                beat.last     = 1'b1;
            end
            default:
            begin
                beat.has_byte = 1'b0;
                beat.last     = 1'b1;
            end
        endcase
        busy_next = !beat.last;
    end

    // A beat moves into the output register when it is empty or drains.
    assign load = q_valid && (!valid_reg || out_ready);
    assign pop  = load && beat.last;

    // Sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            ph_reg    <= PH_NOBYTE;
            dig_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg  <= busy_next;
                ph_reg    <= ph_next;
                dig_reg   <= dig_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= beat;
    end

endmodule

FILE: rtl/core/http_body_framer_core.sv
// Top level of the HTTP body framer: stream ports, field packing, and the
// front end, job queue and back end. Depends on hbf_pkg, hbf_front,
// hbf_queue and hbf_back.
//
// Channel   Dir  Accepted when                 Carries
// s_axis    in   s_axis_tvalid & s_axis_tready one response item (start, byte, end)
// m_axis    out  m_axis_tvalid & m_axis_tready one framed body beat or status beat
//
// Plain body bytes flow at one per cycle unless the output stalls or the queue
// fills. A chunk byte is sent as hex digits and CRLF (first byte), the data, and
// CRLF (last byte); the end of a chunked body as the digit 0, CRLF, CRLF. The
// back-end sequencer emits one beat per cycle unless the output stalls.
// Reset clears the response state (no body mode), the queue and the output.
// The four-entry job queue lets the input keep flowing while the output stalls.
module http_body_framer_core #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // status_code[9:0], is_head[10], minor_version[14:11], keep_alive[15],
    // has_length[16], decl_length[48:17], data_byte[56:49],
    // chunk_length[88:57], zero[95:89]
    input  logic [95:0] s_axis_tdata,
    // kind[1:0], chunk_first[2]
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], status[9:8], body_mode[11:10], close_connection[12],
    // zero[15:13]
    output logic [15:0] m_axis_tdata,
    // has_byte[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import hbf_pkg::*;

    item_t item;
    job_t  push_job;
    job_t  head;
    res_t  res;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;

    // Unpack the input beat.
    always_comb
    begin
        item.kind          = s_axis_tuser[1:0];
        item.status_code   = s_axis_tdata[9:0];
        item.is_head       = s_axis_tdata[10];
        item.minor_version = s_axis_tdata[14:11];
        item.keep_alive    = s_axis_tdata[15];
        item.has_length    = s_axis_tdata[16];
        item.decl_length   = s_axis_tdata[48:17];
        item.data_byte     = s_axis_tdata[56:49];
        item.chunk_first   = s_axis_tuser[2];
        item.chunk_last    = s_axis_tlast;
        item.chunk_length  = s_axis_tdata[88:57];
    end

    hbf_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .item     (item),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    hbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (head)
    );

    hbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack the output beat.
    assign m_axis_tdata = {3'b000, res.close, res.mode, res.status, res.out_byte};
    assign m_axis_tuser = res.has_byte;
    assign m_axis_tlast = res.last;

endmodule
